@@ hdl/fkf_pkg.sv @@
// Shared types, constants and helper functions of the 6x6 kernel filter.
`default_nettype none
package fkf_pkg;

  localparam int KSIZE          = 6;
  localparam int LINES          = KSIZE - 1;
  localparam int PIX_W          = 8;
  localparam int SLOT_W         = 3;
  localparam int LINE_WORD_W    = LINES * PIX_W;
  localparam int SUM_W          = 16;
  localparam int SAT_LIMIT      = 4080;
  localparam int PIX_MAX        = 255;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RST_WIDTH      = 1280;
  localparam int RST_HEIGHT     = 1024;
  localparam int CFG_WIDTH_W    = 12;
  localparam int CFG_HEIGHT_W   = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 2;

  localparam int OQ_DEPTH       = 8;
  localparam int QPTR_W         = $clog2(OQ_DEPTH);
  localparam int PEND_W         = $clog2(OQ_DEPTH + 1);

  localparam int KERNEL [KSIZE][KSIZE] = '{
    '{1, 1,   1,   1, 1, 1},
    '{1, 2,   3,   3, 2, 1},
    '{1, 3, -13, -13, 3, 1},
    '{1, 3, -13, -13, 3, 1},
    '{1, 2,   3,   3, 2, 1},
    '{1, 1,   1,   1, 1, 1}
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic signed [SUM_W-1:0] rsum_t;

  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } fkf_tag_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } fkf_res_t;

  // Clamp a programmed size to the supported range; zero counts as one.
  function automatic int eff_size(input int v, input int lim);
    int r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v == 0) begin
      r = 1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/fkf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module fkf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/fkf_window.sv @@
// Line-store write-back with forwarding, 6x6 window registers and weighted row sums.
`default_nettype none
module fkf_window
  import fkf_pkg::*;
#(
  parameter int ADDR_W = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   p1_valid,
  input  wire fkf_tag_t               p1_tag,
  input  wire logic [SLOT_W-1:0]      p1_slot,
  input  wire logic [ADDR_W-1:0]      p1_addr,
  input  wire logic [PIX_W-1:0]       p1_pix,
  input  wire logic [LINE_WORD_W-1:0] rd_word,
  output logic                        wr_en,
  output logic      [ADDR_W-1:0]      wr_addr,
  output logic      [LINE_WORD_W-1:0] wr_data,
  output logic                        rs_valid,
  output fkf_tag_t                    rs_tag,
  output rsum_t                       rs_sum [KSIZE]
);

  logic [LINE_WORD_W-1:0] fwd_word_r;
  logic [ADDR_W-1:0]      fwd_addr_r;
  logic                   fwd_valid_r;
  logic [LINE_WORD_W-1:0] word;
  logic [LINE_WORD_W-1:0] new_word;
  logic [PIX_W-1:0]       colv [KSIZE];
  logic [PIX_W-1:0]       win_r [KSIZE][KSIZE];
  logic                   win_valid_r;
  fkf_tag_t               win_tag_r;
  rsum_t                  rs_nxt [KSIZE];
  rsum_t                  rs_sum_r [KSIZE];
  logic                   rs_valid_r;
  fkf_tag_t               rs_tag_r;

  // The previous item wrote its word in the same cycle this item read it, so the
  // RAM returned the stale word.
  assign word = (fwd_valid_r && (fwd_addr_r == p1_addr)) ? fwd_word_r : rd_word;

  always_comb begin
    logic [SLOT_W:0] sidx;
    sidx = '0;
    new_word = word;
    new_word[p1_slot*PIX_W +: PIX_W] = p1_pix;
    for (int k = 0; k < LINES; k++) begin
      sidx = {1'b0, p1_slot} + (SLOT_W+1)'(k);
      if (sidx >= (SLOT_W+1)'(LINES)) begin
        sidx = sidx - (SLOT_W+1)'(LINES);
      end
      colv[k] = word[sidx*PIX_W +: PIX_W];
    end
    colv[LINES] = p1_pix;
  end

  assign wr_en   = p1_valid;
  assign wr_addr = p1_addr;
  assign wr_data = new_word;

  always_ff @(posedge clk) begin
    fwd_word_r <= new_word;
    fwd_addr_r <= p1_addr;
    win_tag_r  <= p1_tag;
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
      win_valid_r <= 1'b0;
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      fwd_valid_r <= p1_valid;
      win_valid_r <= p1_valid;
      if (p1_valid) begin
        for (int i = 0; i < KSIZE; i++) begin
          for (int j = 0; j < KSIZE - 1; j++) begin
            win_r[i][j] <= win_r[i][j+1];
          end
          win_r[i][KSIZE-1] <= colv[i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < KSIZE; i++) begin
      rs_nxt[i] = '0;
      for (int j = 0; j < KSIZE; j++) begin
        rs_nxt[i] = rs_nxt[i] + rsum_t'(KERNEL[i][j]) * rsum_t'({1'b0, win_r[i][j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    rs_tag_r <= win_tag_r;
    for (int i = 0; i < KSIZE; i++) begin
      rs_sum_r[i] <= rs_nxt[i];
    end
    if (!rst_n) begin
      rs_valid_r <= 1'b0;
    end else begin
      rs_valid_r <= win_valid_r;
    end
  end

  assign rs_valid = rs_valid_r;
  assign rs_tag   = rs_tag_r;
  assign rs_sum   = rs_sum_r;

endmodule
`default_nettype wire

@@ hdl/fkf_sum.sv @@
// Final kernel sum, saturation and scaling of one window.
`default_nettype none
module fkf_sum
  import fkf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     rs_valid,
  input  wire fkf_tag_t rs_tag,
  input  wire rsum_t    rs_sum [KSIZE],
  output logic          push,
  output fkf_res_t      res,
  output logic          drop
);

  rsum_t    total;
  fkf_res_t res_nxt;
  fkf_res_t res_r;
  logic     push_r;

  always_comb begin
    total = '0;
    for (int i = 0; i < KSIZE; i++) begin
      total = total + rs_sum[i];
    end
    if (total > rsum_t'(SAT_LIMIT)) begin
      res_nxt.pix = PIX_W'(PIX_MAX);
    end else if (total < 0) begin
      res_nxt.pix = '0;
    end else begin
      res_nxt.pix = total[PIX_W+3:4];
    end
    res_nxt.row_end   = rs_tag.row_end;
    res_nxt.frame_end = rs_tag.frame_end;
  end

  // Positions outside the valid window range leave the pipeline here.
  assign drop = rs_valid && !rs_tag.emit;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= rs_valid && rs_tag.emit;
    end
  end

  assign push = push_r;
  assign res  = res_r;

endmodule
`default_nettype wire

@@ hdl/fkf_outq.sv @@
// Small result queue that decouples the filter pipeline from the output handshake.
`default_nettype none
module fkf_outq
  import fkf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire fkf_res_t push_data,
  input  wire logic     pop,
  output logic          q_valid,
  output fkf_res_t      q_data
);

  fkf_res_t          q_r [OQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [PEND_W-1:0] cnt_r;
  logic [PEND_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + PEND_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - PEND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_data  = q_r[rd_ptr_r];

endmodule
`default_nettype wire

@@ hdl/fir_6x6_kernel_filter.sv @@
// Top level of the 6x6 zero-sum kernel filter over a raster pixel stream.
//
//   Channel   Prefix  Direction  Moves
//   --------  ------  ---------  -------------------------------------------------
//   input     in_     in         one source pixel per transfer, raster order
//   output    out_    out        one filtered pixel with row and frame end flags
//   config    cfg_    in         register index and data (image width, height)
//
// One source pixel is taken every clock while in_ready is high; the single RAM
// read of the line-store word for the current column sets that pace. Results pass
// the read, window, row sum and result registers. Reset is synchronous and needs
// no clearing pass: line-store words are always written before a result depends
// on them. When the output side stalls, up to eight accepted pixels are held in
// flight and in the result queue before in_ready drops.
`default_nettype none
module fir_6x6_kernel_filter
  import fkf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [PIX_W-1:0]       in_source_pixel,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [PIX_W-1:0]       out_filtered_pixel,
  output logic                        out_row_end,
  output logic                        out_frame_end,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int EW_W = CW + 1;
  localparam int EH_W = RW + 1;

  // Effective frame size, already clamped to the supported range.
  logic [EW_W-1:0]   ew_r;
  logic [EH_W-1:0]   eh_r;

  // Raster position of the next pixel; slot_r tracks the row modulo five, which
  // picks the byte of the line-store word that this row overwrites.
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [SLOT_W-1:0] slot_r;

  logic              in_xfer;
  logic              out_xfer;
  logic              cfg_xfer;
  logic              cfg_hit;
  logic [EW_W-1:0]   col_inc;
  logic [EH_W-1:0]   row_inc;
  fkf_tag_t          tag_nxt;

  // Stage that waits on the RAM read.
  logic              p1_valid_r;
  fkf_tag_t          p1_tag_r;
  logic [SLOT_W-1:0] p1_slot_r;
  logic [CW-1:0]     p1_addr_r;
  logic [PIX_W-1:0]  p1_pix_r;

  logic [LINE_WORD_W-1:0] rd_word;
  logic                   wr_en;
  logic [CW-1:0]          wr_addr;
  logic [LINE_WORD_W-1:0] wr_data;

  logic              rs_valid;
  fkf_tag_t          rs_tag;
  rsum_t             rs_sum [KSIZE];
  logic              push;
  logic              drop;
  fkf_res_t          res;
  fkf_res_t          q_data;

  // Items accepted and not yet dropped or delivered. Bounding this by the queue
  // depth means the pipeline itself never has to stall.
  logic [PEND_W-1:0] pend_r;
  logic [PEND_W-1:0] pend_nxt;

  assign in_ready  = (pend_r < PEND_W'(OQ_DEPTH));
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_xfer && ((cfg_index == REG_IMAGE_WIDTH) ||
                                  (cfg_index == REG_IMAGE_HEIGHT));

  assign col_inc = {1'b0, col_r} + EW_W'(1);
  assign row_inc = {1'b0, row_r} + EH_W'(1);

  // A window ends at this pixel when both its row and column are past the first
  // five and the window still fits in front of the last row and column. The
  // flags mark the last window of a row and of the frame.
  always_comb begin
    tag_nxt.emit      = (row_r >= RW'(LINES)) && (col_r >= CW'(LINES)) &&
                        (row_inc < eh_r) && (col_inc < ew_r);
    tag_nxt.row_end   = ((col_inc + EW_W'(1)) == ew_r);
    tag_nxt.frame_end = ((col_inc + EW_W'(1)) == ew_r) && ((row_inc + EH_W'(1)) == eh_r);
  end

  // Register writes restart the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r   <= EW_W'(eff_size(RST_WIDTH, MAX_WIDTH));
      eh_r   <= EH_W'(eff_size(RST_HEIGHT, MAX_HEIGHT));
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          ew_r <= EW_W'(eff_size(int'(cfg_data[CFG_WIDTH_W-1:0]), MAX_WIDTH));
        end
        REG_IMAGE_HEIGHT: begin
          eh_r <= EH_W'(eff_size(int'(cfg_data[CFG_HEIGHT_W-1:0]), MAX_HEIGHT));
        end
        default: begin
        end
      endcase
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (in_xfer) begin
      if (col_inc >= ew_r) begin
        col_r <= '0;
        if (row_inc >= eh_r) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_inc[RW-1:0];
          slot_r <= (slot_r == SLOT_W'(LINES - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_r <= col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_tag_r  <= tag_nxt;
    p1_slot_r <= slot_r;
    p1_addr_r <= col_r;
    p1_pix_r  <= in_source_pixel;
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= in_xfer;
    end
  end

  // One word per column holds that column's pixel from each of the last five rows.
  fkf_ram #(
    .WIDTH (LINE_WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_xfer),
    .raddr (col_r),
    .rdata (rd_word)
  );

  fkf_window #(
    .ADDR_W (CW)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .p1_valid (p1_valid_r),
    .p1_tag   (p1_tag_r),
    .p1_slot  (p1_slot_r),
    .p1_addr  (p1_addr_r),
    .p1_pix   (p1_pix_r),
    .rd_word  (rd_word),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rs_valid (rs_valid),
    .rs_tag   (rs_tag),
    .rs_sum   (rs_sum)
  );

  fkf_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .rs_valid (rs_valid),
    .rs_tag   (rs_tag),
    .rs_sum   (rs_sum),
    .push     (push),
    .res      (res),
    .drop     (drop)
  );

  fkf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pop       (out_xfer),
    .q_valid   (out_valid),
    .q_data    (q_data)
  );

  assign out_filtered_pixel = q_data.pix;
  assign out_row_end        = q_data.row_end;
  assign out_frame_end      = q_data.frame_end;

  always_comb begin
    pend_nxt = pend_r + PEND_W'(in_xfer) - PEND_W'(out_xfer) - PEND_W'(drop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // The credit count never runs past the queue depth.
  assert property (@(posedge clk) disable iff (!rst_n) pend_r <= PEND_W'(OQ_DEPTH))
    else $error("pending item count exceeds result queue depth");

  // A result on the output always belongs to an item still counted as pending.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (pend_r != '0))
    else $error("result shown with no pending item");

  // The last window of a frame is also the last window of its row.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_frame_end) |-> out_row_end)
    else $error("frame end without row end");

  // A pixel accepted now reaches the line-store write in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> wr_en)
    else $error("accepted pixel did not write back its line-store word");

endmodule
`default_nettype wire
